### src/a85_pkg.sv
// ----------------------------------------------------------------------------
// a85_pkg: shared constants for the ascii85 stream encoder
// Character codes, digit widths and the reciprocal used for division by 85.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package a85_pkg;

  // one base-85 digit value, 0 to 84
  localparam int unsigned DIG_W = 7;
  // quotient of a 32-bit value by 85 fits in 26 bits
  localparam int unsigned QUO_W = 26;

  // x / 85 == (x * B85_RECIP) >> B85_SHIFT for every 32-bit x
  localparam logic [31:0] B85_RECIP = 32'd3233857729;
  localparam int unsigned B85_SHIFT = 38;
  localparam logic [6:0]  B85_BASE  = 7'd85;

  // character codes
  localparam logic [6:0] CH_OFFSET = 7'd33;   // '!'
  localparam logic [6:0] CH_LT     = 7'h3C;   // '<'
  localparam logic [6:0] CH_TILDE  = 7'h7E;   // '~'
  localparam logic [6:0] CH_GT     = 7'h3E;   // '>'

  // bytes in one group, digits in one full group
  localparam logic [2:0] GROUP_BYTES = 3'd4;
  localparam logic [2:0] GROUP_DIGS  = 3'd5;

endpackage

`default_nettype wire

### src/ascii85_stream_encoder.sv
// ----------------------------------------------------------------------------
// ascii85_stream_encoder: byte stream to ascii85 text
// Takes one raw byte per word and gives one text character per word,
// framed by "<~" and "~>", with four-byte groups turned into five digits.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                 | tlast
//  in_     | in  | [7:0] data_byte       | final_byte
//  out_    | out | [6:0] text_char, [7]0 | run_last
//
//  a byte that causes no character leaves the sequencer idle; in_tready is high only
//  while the sequencer is idle
//  a full group takes five divide-by-85 steps (ST_MUL, then ST_REM) on the
//  shared divider, then one character per cycle while out_tready allows
//  opening and closing delimiters add two characters each
//  rst_n is synchronous and clears the sequencer, group state and output
//  a stalled out_tready holds the sequencer in its emit state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ascii85_stream_encoder
  import a85_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,   // final_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata,  // [6:0] text_char, [7] zero
  output logic            out_tlast   // run_last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_REM,
    ST_OPEN0,
    ST_OPEN1,
    ST_DIG,
    ST_CLOSE0,
    ST_CLOSE1
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             opened_r, opened_nxt;
  logic             fin_r, fin_nxt;
  logic             open_pend_r, open_pend_nxt;
  logic             has_dig_r, has_dig_nxt;
  logic [2:0]       iter_r, iter_nxt;
  logic [2:0]       left_r, left_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [6:0]       out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;

  logic [31:0]      acc_r, acc_nxt;
  logic [31:0]      work_r, work_nxt;
  logic [DIG_W-1:0] digits_r   [5];
  logic [DIG_W-1:0] digits_nxt [5];

  logic             in_acc;
  logic             slot_free;
  logic [31:0]      acc_shift;
  logic [2:0]       cnt_inc;
  logic             full;
  logic [31:0]      pad_val;
  logic [QUO_W-1:0] div_quo;
  logic [DIG_W-1:0] div_rem;
  logic             div_load;

  // handshakes
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // group packing on an accepted byte
  assign acc_shift = {acc_r[23:0], in_tdata};
  assign cnt_inc   = 3'(cnt_r) + 3'd1;
  assign full      = (cnt_inc == GROUP_BYTES);

  // zero padding of a partial group
  always_comb begin
    unique case (cnt_r)
      2'd0:    pad_val = acc_shift << 24;
      2'd1:    pad_val = acc_shift << 16;
      2'd2:    pad_val = acc_shift << 8;
      default: pad_val = acc_shift;
    endcase
  end

  // shared divide-by-85 unit
  assign div_load = (state_r == ST_MUL);

  a85_div85 u_div (
    .clk  (clk),
    .load (div_load),
    .x    (work_r),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    opened_nxt    = opened_r;
    fin_nxt       = fin_r;
    open_pend_nxt = open_pend_r;
    has_dig_nxt   = has_dig_r;
    iter_nxt      = iter_r;
    left_nxt      = left_r;
    acc_nxt       = acc_r;
    work_nxt      = work_r;
    digits_nxt    = digits_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          acc_nxt       = acc_shift;
          work_nxt      = pad_val;
          iter_nxt      = 3'd0;
          left_nxt      = full ? GROUP_DIGS : (cnt_inc + 3'd1);
          fin_nxt       = in_tlast;
          open_pend_nxt = !opened_r;
          has_dig_nxt   = full || in_tlast;
          cnt_nxt       = (full || in_tlast) ? 2'd0 : cnt_inc[1:0];
          opened_nxt    = !in_tlast;
          if (full || in_tlast) begin
            state_nxt = ST_MUL;
          end else if (!opened_r) begin
            state_nxt = ST_OPEN0;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_REM;
      end
      ST_REM: begin
        // new digit enters at the bottom, the most significant ends there
        digits_nxt[0] = div_rem;
        for (int i = 1; i < 5; i++) begin
          digits_nxt[i] = digits_r[i-1];
        end
        work_nxt = 32'(div_quo);
        iter_nxt = iter_r + 3'd1;
        if (iter_r == (GROUP_DIGS - 3'd1)) begin
          state_nxt = open_pend_r ? ST_OPEN0 : ST_DIG;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_OPEN0: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_LT;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_OPEN1;
        end
      end
      ST_OPEN1: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_TILDE;
          out_last_nxt  = !has_dig_r && !fin_r;
          if (has_dig_r) begin
            state_nxt = ST_DIG;
          end else if (fin_r) begin
            state_nxt = ST_CLOSE0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIG: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digits_r[0] + CH_OFFSET;
          out_last_nxt  = (left_r == 3'd1) && !fin_r;
          for (int i = 0; i < 4; i++) begin
            digits_nxt[i] = digits_r[i+1];
          end
          left_nxt = left_r - 3'd1;
          if (left_r == 3'd1) begin
            state_nxt = fin_r ? ST_CLOSE0 : ST_IDLE;
          end
        end
      end
      ST_CLOSE0: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_TILDE;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_CLOSE1;
        end
      end
      ST_CLOSE1: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_GT;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 2'd0;
      opened_r    <= 1'b0;
      fin_r       <= 1'b0;
      open_pend_r <= 1'b0;
      has_dig_r   <= 1'b0;
      iter_r      <= 3'd0;
      left_r      <= 3'd0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      opened_r    <= opened_nxt;
      fin_r       <= fin_nxt;
      open_pend_r <= open_pend_nxt;
      has_dig_r   <= has_dig_nxt;
      iter_r      <= iter_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    work_r     <= work_nxt;
    out_char_r <= out_char_nxt;
    for (int i = 0; i < 5; i++) begin
      digits_r[i] <= digits_nxt[i];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

  // checks
  a_rem_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REM) |-> ($past(state_r) == ST_MUL))
    else $error("divider remainder read without a product step");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REM) |-> (div_rem < B85_BASE))
    else $error("divide-by-85 remainder out of range");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_char_r >= CH_OFFSET) && (out_char_r <= CH_TILDE)))
    else $error("output character outside printable range");

  a_dig_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIG) |-> ((left_r != 3'd0) && (left_r <= GROUP_DIGS)))
    else $error("digit count out of range while emitting");

endmodule

`default_nettype wire

### src/a85_div85.sv
// ----------------------------------------------------------------------------
// a85_div85: divide-by-85 step unit
// On load it registers the reciprocal-product quotient and x; the
// quotient and remainder are valid in the following cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module a85_div85
  import a85_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic [31:0]      x,
  output logic      [QUO_W-1:0] quo,
  output logic      [DIG_W-1:0] rem
);

  logic [63:0]      prod;
  logic [QUO_W-1:0] quo_r;
  logic [31:0]      x_r;
  logic [31:0]      q_ext;
  logic [31:0]      q_times_base;
  logic [31:0]      diff;

  // reciprocal multiply, registered before the back-multiply
  assign prod = 64'(x) * 64'(B85_RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      quo_r <= prod[B85_SHIFT +: QUO_W];
      x_r   <= x;
    end
  end

  // remainder: x - 85*q, with 85*q = 64q + 16q + 4q + q
  assign q_ext        = 32'(quo_r);
  assign q_times_base = (q_ext << 6) + (q_ext << 4) + (q_ext << 2) + q_ext;
  assign diff         = x_r - q_times_base;

  assign quo = quo_r;
  assign rem = diff[DIG_W-1:0];

endmodule

`default_nettype wire
